// ===== rtl/core/mskf_pkg.sv =====
// Shared types, codes and saturation helpers for the motor state Kalman filter.
// No dependencies; used by motor_state_kalman_filter_unit.
package mskf_pkg;

  localparam int STATE_COUNT = 4;
  localparam int WORD_W      = 32;
  localparam int ACC_W       = 64;

  localparam logic [2:0] OP_ESTIMATE = 3'd0;
  localparam logic [2:0] OP_PREDICT  = 3'd1;
  localparam logic [2:0] OP_UPDATE   = 3'd2;
  localparam logic [2:0] OP_LOAD_A   = 3'd3;
  localparam logic [2:0] OP_LOAD_B   = 3'd4;
  localparam logic [2:0] OP_RESET    = 3'd5;

  localparam logic [2:0] CFG_Q_POSITION = 3'd0;
  localparam logic [2:0] CFG_Q_VELOCITY = 3'd1;
  localparam logic [2:0] CFG_Q_LOAD     = 3'd2;
  localparam logic [2:0] CFG_Q_CURRENT  = 3'd3;
  localparam logic [2:0] CFG_R_MEASURE  = 3'd4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] voltage;
    logic signed [31:0] measured_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] est_load_torque;
    logic signed [31:0] est_current;
    logic               saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_UINIT, ST_DSET, ST_DIV, ST_DFIN, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    PS_XP, PS_AP, PS_PP, PS_XU, PS_PU
  } pass_t;

  function automatic logic ovf32(input logic signed [ACC_W-1:0] v);
    return (v > 64'sh0000_0000_7FFF_FFFF) || (v < -64'sh0000_0000_8000_0000);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/motor_state_kalman_filter_unit.sv =====
// Top level of the four-state motor Kalman filter: sequencer, one shared MAC and a
// bit-serial divider. Depends on mskf_pkg.
//
//  port group | direction | handshake           | payload
//  in_        | input     | in_valid / in_stall  | mskf_pkg::in_item_t
//  out_       | output    | out_valid / out_stall| mskf_pkg::out_item_t
//  cfg_       | input     | cfg_we               | cfg_index, cfg_wdata
//
// One multiplier is shared: each product term is a multiply step, then a round and
// accumulate step. Predict is 148 terms; update is 20 terms plus four bit-serial
// divisions; estimate runs predict, then update. Loads and reset go straight to
// completion. in_stall stays high from a transfer until the result is placed in
// the output register; a held result does not block the next transfer.
// rst_n restores x to zero, P to 100 on the diagonal, A, B and the Q and R registers to zero.
module motor_state_kalman_filter_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mskf_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mskf_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_wdata
);

  localparam int NUMW = 32 + FRAC_BITS;
  localparam int CW   = $clog2(NUMW + 1);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] P_INIT = 32'sd100 <<< FRAC_BITS;

  mskf_pkg::state_t state_r, state_nxt;
  mskf_pkg::pass_t  pass_r;

  logic signed [31:0] a_r  [16];
  logic signed [31:0] p_r  [16];
  logic signed [31:0] ap_r [16];
  logic signed [31:0] b_r  [4];
  logic signed [31:0] x_r  [4];
  logic signed [31:0] nx_r [4];
  logic signed [31:0] g_r  [4];

  logic signed [31:0] qp_r, qv_r, ql_r, qc_r;
  logic [30:0]        rm_r;

  logic [1:0]  i_r, j_r;
  logic [2:0]  k_r;
  logic        est_r, sat_r;
  logic signed [31:0] u_r, pos_r, innov_r, s_r;
  logic signed [63:0] prod_r, acc_r;
  logic [32:0]      rem_r;
  logic [NUMW-1:0]  quo_r;
  logic [CW-1:0]    cnt_r;
  logic             neg_r;
  logic             out_valid_r;
  mskf_pkg::out_item_t out_r;

  logic signed [31:0] op_a, op_b, bias;
  logic               sub;
  logic [2:0]         nterm;
  logic               term_last, elem_last;
  logic signed [63:0] rp, acc_sum, fin;
  logic signed [63:0] innov_w, s_w;
  logic [32:0]        rem_sh;
  logic signed [32:0] pcol;
  logic [31:0]        pmag;
  logic signed [63:0] qsig;
  logic               take_in, out_free;

  assign in_stall  = (state_r != mskf_pkg::ST_IDLE);
  assign take_in   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    op_a  = g_r[i_r];
    op_b  = innov_r;
    bias  = '0;
    sub   = 1'b0;
    nterm = 3'd1;
    elem_last = (i_r == 2'd3);
    case (pass_r)
      mskf_pkg::PS_XP: begin
        nterm = 3'd5;
        if (k_r == 3'd0) begin
          op_a = b_r[i_r];
          op_b = u_r;
        end else begin
          op_a = a_r[{i_r, 2'(k_r - 3'd1)}];
          op_b = x_r[2'(k_r - 3'd1)];
        end
      end
      mskf_pkg::PS_AP: begin
        nterm = 3'd4;
        op_a = a_r[{i_r, k_r[1:0]}];
        op_b = p_r[{k_r[1:0], j_r}];
        elem_last = (i_r == 2'd3) && (j_r == 2'd3);
      end
      mskf_pkg::PS_PP: begin
        nterm = 3'd4;
        op_a = ap_r[{i_r, k_r[1:0]}];
        op_b = a_r[{j_r, k_r[1:0]}];
        elem_last = (i_r == 2'd3) && (j_r == 2'd3);
        if (i_r == j_r) begin
          case (i_r)
            2'd0:    bias = qp_r;
            2'd1:    bias = qv_r;
            2'd2:    bias = ql_r;
            default: bias = qc_r;
          endcase
        end
      end
      mskf_pkg::PS_XU: begin
        bias = x_r[i_r];
      end
      default: begin
        op_b = p_r[{2'd0, j_r}];
        bias = p_r[{i_r, j_r}];
        sub  = 1'b1;
        elem_last = (i_r == 2'd0) && (j_r == 2'd3);
      end
    endcase
    term_last = (k_r == nterm - 3'd1);
  end

  assign rp      = (prod_r + HALF) >>> FRAC_BITS;
  assign acc_sum = sub ? acc_r - rp : acc_r + rp;
  assign fin     = acc_sum + 64'(bias);
  assign innov_w = 64'(pos_r) - 64'(x_r[0]);
  assign s_w     = 64'(p_r[0]) + 64'({1'b0, rm_r});
  assign rem_sh  = {rem_r[31:0], quo_r[NUMW-1]};
  assign pcol    = 33'(p_r[{i_r, 2'd0}]);
  assign pmag    = 32'(pcol[32] ? -pcol : pcol);
  assign qsig    = neg_r ? -64'(quo_r) : 64'(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mskf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mskf_pkg::ST_IDLE: begin
        if (take_in) begin
          unique case (in_data.opcode) inside
            mskf_pkg::OP_ESTIMATE, mskf_pkg::OP_PREDICT: state_nxt = mskf_pkg::ST_MUL;
            mskf_pkg::OP_UPDATE: state_nxt = mskf_pkg::ST_UINIT;
            mskf_pkg::OP_LOAD_A, mskf_pkg::OP_LOAD_B, mskf_pkg::OP_RESET:
              state_nxt = mskf_pkg::ST_DONE;
            default: state_nxt = mskf_pkg::ST_IDLE;
          endcase
        end
      end
      mskf_pkg::ST_MUL: state_nxt = mskf_pkg::ST_ACC;
      mskf_pkg::ST_ACC: begin
        state_nxt = mskf_pkg::ST_MUL;
        if (term_last && elem_last) begin
          if (pass_r == mskf_pkg::PS_PP) begin
            state_nxt = est_r ? mskf_pkg::ST_UINIT : mskf_pkg::ST_DONE;
          end else if (pass_r == mskf_pkg::PS_PU) begin
            state_nxt = mskf_pkg::ST_DONE;
          end
        end
      end
      mskf_pkg::ST_UINIT: state_nxt = (s_w > 0) ? mskf_pkg::ST_DSET : mskf_pkg::ST_DONE;
      mskf_pkg::ST_DSET:  state_nxt = mskf_pkg::ST_DIV;
      mskf_pkg::ST_DIV: begin
        if (cnt_r == CW'(NUMW - 1)) begin
          state_nxt = mskf_pkg::ST_DFIN;
        end
      end
      mskf_pkg::ST_DFIN: state_nxt = (i_r == 2'd3) ? mskf_pkg::ST_MUL : mskf_pkg::ST_DSET;
      mskf_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mskf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mskf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pass_r      <= mskf_pkg::PS_XP;
      qp_r <= '0; qv_r <= '0; ql_r <= '0; qc_r <= '0; rm_r <= '0;
      for (int n = 0; n < 16; n++) begin
        a_r[n] <= '0;
        p_r[n] <= (n % 5 == 0) ? P_INIT : '0;
      end
      for (int n = 0; n < 4; n++) begin
        b_r[n] <= '0;
        x_r[n] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mskf_pkg::CFG_Q_POSITION: qp_r <= cfg_wdata;
          mskf_pkg::CFG_Q_VELOCITY: qv_r <= cfg_wdata;
          mskf_pkg::CFG_Q_LOAD:     ql_r <= cfg_wdata;
          mskf_pkg::CFG_Q_CURRENT:  qc_r <= cfg_wdata;
          mskf_pkg::CFG_R_MEASURE:  rm_r <= cfg_wdata[30:0];
          default: ;
        endcase
      end

      if (state_r == mskf_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_r <= '{x_r[0], x_r[1], x_r[2], x_r[3], sat_r};
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        mskf_pkg::ST_IDLE: begin
          if (take_in) begin
            sat_r <= 1'b0;
            est_r <= (in_data.opcode == mskf_pkg::OP_ESTIMATE);
            u_r   <= in_data.voltage;
            pos_r <= in_data.measured_position;
            pass_r <= mskf_pkg::PS_XP;
            i_r <= '0; j_r <= '0; k_r <= '0;
            acc_r <= '0;
            case (in_data.opcode)
              mskf_pkg::OP_LOAD_A: a_r[in_data.coef_index] <= in_data.coef_value;
              mskf_pkg::OP_LOAD_B: begin
                if (in_data.coef_index[3:2] == 2'd0) begin
                  b_r[in_data.coef_index[1:0]] <= in_data.coef_value;
                end
              end
              mskf_pkg::OP_RESET: begin
                for (int n = 0; n < 16; n++) begin
                  p_r[n] <= (n % 5 == 0) ? P_INIT : '0;
                end
                for (int n = 0; n < 4; n++) begin
                  x_r[n] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        mskf_pkg::ST_MUL: prod_r <= 64'(op_a) * 64'(op_b);
        mskf_pkg::ST_ACC: begin
          if (!term_last) begin
            acc_r <= acc_sum;
            k_r   <= k_r + 3'd1;
          end else begin
            acc_r <= '0;
            k_r   <= '0;
            if (mskf_pkg::ovf32(fin)) begin
              sat_r <= 1'b1;
            end
            case (pass_r)
              mskf_pkg::PS_XP: begin
                nx_r[i_r] <= mskf_pkg::sat32(fin);
                i_r <= i_r + 2'd1;
                if (elem_last) begin
                  for (int n = 0; n < 3; n++) begin
                    x_r[n] <= nx_r[n];
                  end
                  x_r[3] <= mskf_pkg::sat32(fin);
                  pass_r <= mskf_pkg::PS_AP;
                  j_r <= '0;
                end
              end
              mskf_pkg::PS_AP: begin
                ap_r[{i_r, j_r}] <= mskf_pkg::sat32(fin);
                {i_r, j_r} <= {i_r, j_r} + 4'd1;
                if (elem_last) begin
                  pass_r <= mskf_pkg::PS_PP;
                end
              end
              mskf_pkg::PS_PP: begin
                p_r[{i_r, j_r}] <= mskf_pkg::sat32(fin);
                {i_r, j_r} <= {i_r, j_r} + 4'd1;
              end
              mskf_pkg::PS_XU: begin
                x_r[i_r] <= mskf_pkg::sat32(fin);
                if (elem_last) begin
                  pass_r <= mskf_pkg::PS_PU;
                  i_r <= 2'd3;
                  j_r <= '0;
                end else begin
                  i_r <= i_r + 2'd1;
                end
              end
              default: begin
                p_r[{i_r, j_r}] <= mskf_pkg::sat32(fin);
                j_r <= j_r + 2'd1;
                if (j_r == 2'd3) begin
                  i_r <= i_r - 2'd1;
                end
              end
            endcase
          end
        end
        mskf_pkg::ST_UINIT: begin
          innov_r <= mskf_pkg::sat32(innov_w);
          s_r     <= mskf_pkg::sat32(s_w);
          i_r     <= '0;
          if (mskf_pkg::ovf32(innov_w) || mskf_pkg::ovf32(s_w) || !(s_w > 0)) begin
            sat_r <= 1'b1;
          end
        end
        mskf_pkg::ST_DSET: begin
          neg_r <= pcol[32];
          quo_r <= NUMW'(pmag) << FRAC_BITS;
          rem_r <= '0;
          cnt_r <= '0;
        end
        mskf_pkg::ST_DIV: begin
          cnt_r <= cnt_r + CW'(1);
          if (rem_sh >= {1'b0, s_r}) begin
            rem_r <= rem_sh - {1'b0, s_r};
            quo_r <= {quo_r[NUMW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[NUMW-2:0], 1'b0};
          end
        end
        mskf_pkg::ST_DFIN: begin
          g_r[i_r] <= mskf_pkg::sat32(qsig);
          if (mskf_pkg::ovf32(qsig)) begin
            sat_r <= 1'b1;
          end
          i_r <= i_r + 2'd1;
          if (i_r == 2'd3) begin
            pass_r <= mskf_pkg::PS_XU;
            k_r    <= '0;
            acc_r  <= '0;
          end
        end
        mskf_pkg::ST_DONE: ;
        default: ;
      endcase
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == mskf_pkg::ST_DONE))
    else $error("result raised outside the completion step");

  a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mskf_pkg::ST_DIV) |-> (!s_r[31] && s_r != '0))
    else $error("division entered with nonpositive innovation variance");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mskf_pkg::ST_DIV) |-> (rem_r < {1'b0, s_r}))
    else $error("divider remainder out of range");

endmodule
